FILE: rtl/sanp_pkg.sv
`default_nettype none
package sanp_pkg;

	localparam int unsigned MAX_ORDER_DEF = 13;
	localparam logic [3:0]  ORDER_RESET   = 4'd10;
	localparam int unsigned ORDER_W       = 4;
	localparam int unsigned COS_TERMS     = 10;
	localparam int unsigned SQRT_STAGES   = 16;

	localparam logic [33:0] PI_Q32  = 34'd13493037704;
	localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;

	typedef struct packed {
		logic        neg;
		logic [31:0] pc;
	} sanp_side_t;

	typedef struct packed {
		logic [32:0] za;
		logic        neg;
		logic [31:0] pc;
	} sanp_mid_t;

	typedef struct packed {
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p10;
		logic [63:0] p11;
	} sanp_pp_t;

	function automatic sanp_pp_t pp_split(input logic [63:0] a, input logic [63:0] b);
		sanp_pp_t p;
		p.p00 = {32'd0, a[31:0]}  * {32'd0, b[31:0]};
		p.p01 = {32'd0, a[31:0]}  * {32'd0, b[63:32]};
		p.p10 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
		p.p11 = {32'd0, a[63:32]} * {32'd0, b[63:32]};
		return p;
	endfunction

	function automatic logic [127:0] pp_sum(input sanp_pp_t p);
		return {p.p11, 64'd0} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
			+ {64'd0, p.p00};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sanp_cstep.sv
`default_nettype none
module sanp_cstep
	import sanp_pkg::*;
#(
	parameter int unsigned D = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_vld,
	input  wire logic [63:0] in_y,
	input  wire logic [62:0] in_c,
	input  wire sanp_side_t  in_side,
	output logic             out_vld,
	output logic [63:0]      out_y,
	output logic [62:0]      out_c,
	output sanp_side_t       out_side
);

	localparam int unsigned   L     = $clog2(D + 1) - 1;
	localparam bit            POW2  = ((D & (D - 1)) == 0);
	localparam logic [127:0]  NUM   = 128'd1 << (64 + L);
	localparam logic [127:0]  RFULL = NUM / D;
	localparam logic [63:0]   RECIP = POW2 ? 64'd0 : RFULL[63:0];
	localparam logic [63:0]   DN    = 64'(D);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [63:0] y_s1, y_s2, y_s3, y_s4, y_s5;
	sanp_side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	sanp_pp_t pp_s1, pp_s3;
	logic [63:0] m_s2, m_s3, m_s4, q_s4;
	logic [62:0] c_s5;

	logic [127:0] prod1, prod3, qsh;
	logic [63:0]  qd, rem, qf;

	always_comb begin
		prod1 = pp_sum(pp_s1);
		prod3 = pp_sum(pp_s3);
		qsh   = prod3 >> (64 + L);
		qd    = q_s4 * DN;
		rem   = m_s4 - qd;
		qf    = q_s4 + ((rem >= DN) ? 64'd1 : 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1   <= pp_split(in_y, {1'b0, in_c});
			y_s1    <= in_y;
			side_s1 <= in_side;
			m_s2    <= prod1[125:62];
			y_s2    <= y_s1;
			side_s2 <= side_s1;
			pp_s3   <= pp_split(m_s2, RECIP);
			m_s3    <= m_s2;
			y_s3    <= y_s2;
			side_s3 <= side_s2;
			q_s4    <= POW2 ? (m_s3 >> L) : qsh[63:0];
			m_s4    <= m_s3;
			y_s4    <= y_s3;
			side_s4 <= side_s3;
			c_s5    <= (qf >= {1'b0, ONE_Q62}) ? 63'd0 : (ONE_Q62 - qf[62:0]);
			y_s5    <= y_s4;
			side_s5 <= side_s4;
		end
	end

	assign out_vld  = vld_s5;
	assign out_y    = y_s5;
	assign out_c    = c_s5;
	assign out_side = side_s5;

endmodule
`default_nettype wire

FILE: rtl/sanp_cos.sv
`default_nettype none
module sanp_cos
	import sanp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_vld,
	input  wire logic [31:0] in_theta,
	input  wire logic [31:0] in_pc,
	output logic             out_vld,
	output logic [32:0]      out_za,
	output sanp_side_t       out_side
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [30:0] u_s1;
	logic [63:0] x_s2, y_s4;
	sanp_pp_t pp_s3;
	sanp_side_t side_s1, side_s2, side_s3, side_s4;

	logic [31:0] tc;
	logic [30:0] u;
	logic        neg;
	logic [64:0] xprod;
	logic [127:0] yprod;

	always_comb begin
		tc = (in_theta > 32'h8000_0000) ? (32'd0 - in_theta) : in_theta;
		if (tc > 32'h4000_0000) begin
			u   = 31'(32'h8000_0000 - tc);
			neg = 1'b1;
		end else begin
			u   = tc[30:0];
			neg = 1'b0;
		end
		xprod = {34'd0, u_s1} * {31'd0, PI_Q32};
		yprod = pp_sum(pp_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1       <= u;
			side_s1.neg <= neg;
			side_s1.pc  <= in_pc;
			x_s2       <= xprod[64:1];
			side_s2    <= side_s1;
			pp_s3      <= pp_split(x_s2, x_s2);
			side_s3    <= side_s2;
			y_s4       <= yprod[125:62];
			side_s4    <= side_s3;
		end
	end

	logic        vld_k  [0:COS_TERMS];
	logic [63:0] y_k    [0:COS_TERMS];
	logic [62:0] c_k    [0:COS_TERMS];
	sanp_side_t  side_k [0:COS_TERMS];

	assign vld_k[0]  = vld_s4;
	assign y_k[0]    = y_s4;
	assign c_k[0]    = ONE_Q62;
	assign side_k[0] = side_s4;

	for (genvar g = 0; g < COS_TERMS; g++) begin : g_term
		localparam int unsigned K = COS_TERMS - g;
		sanp_cstep #(
			.D((2 * K) * (2 * K - 1))
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld_k[g]),
			.in_y     (y_k[g]),
			.in_c     (c_k[g]),
			.in_side  (side_k[g]),
			.out_vld  (vld_k[g+1]),
			.out_y    (y_k[g+1]),
			.out_c    (c_k[g+1]),
			.out_side (side_k[g+1])
		);
	end

	assign out_vld  = vld_k[COS_TERMS];
	assign out_za   = c_k[COS_TERMS][62:30];
	assign out_side = side_k[COS_TERMS];

endmodule
`default_nettype wire

FILE: rtl/sanp_sqrt.sv
`default_nettype none
module sanp_sqrt
	import sanp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_vld,
	input  wire logic [63:0] in_v,
	input  wire sanp_mid_t   in_mid,
	output logic             out_vld,
	output logic [31:0]      out_root,
	output sanp_mid_t        out_mid
);

	function automatic logic [65:0] sq_digit(input logic [33:0] rem, input logic [31:0] root,
			input logic [1:0] dd);
		logic [35:0] rem2;
		logic [35:0] trial;
		rem2  = {rem, dd};
		trial = {2'd0, root, 2'b01};
		if (rem2 >= trial)
			return {34'(rem2 - trial), root[30:0], 1'b1};
		else
			return {rem2[33:0], root[30:0], 1'b0};
	endfunction

	logic        vld_s  [0:SQRT_STAGES];
	logic [33:0] rem_s  [0:SQRT_STAGES];
	logic [31:0] root_s [0:SQRT_STAGES];
	logic [63:0] v_s    [0:SQRT_STAGES];
	sanp_mid_t   mid_s  [0:SQRT_STAGES];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = 34'd0;
	assign root_s[0] = 32'd0;
	assign v_s[0]    = in_v;
	assign mid_s[0]  = in_mid;

	for (genvar g = 1; g <= SQRT_STAGES; g++) begin : g_stage
		localparam int unsigned PH = 33 - 2 * g;
		localparam int unsigned PL = 32 - 2 * g;
		logic [65:0] d1, d2;

		always_comb begin
			d1 = sq_digit(rem_s[g-1], root_s[g-1], v_s[g-1][2*PH+1 -: 2]);
			d2 = sq_digit(d1[65:32], d1[31:0], v_s[g-1][2*PL+1 -: 2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g] <= 1'b0;
			else if (en)
				vld_s[g] <= vld_s[g-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= d2[65:32];
				root_s[g] <= d2[31:0];
				v_s[g]    <= v_s[g-1];
				mid_s[g]  <= mid_s[g-1];
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES];
	assign out_root = root_s[SQRT_STAGES];
	assign out_mid  = mid_s[SQRT_STAGES];

endmodule
`default_nettype wire

FILE: rtl/sanp_map.sv
`default_nettype none
module sanp_map
	import sanp_pkg::*;
#(
	parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [ORDER_W-1:0] order,
	input  wire logic               in_vld,
	input  wire logic [31:0]        in_r,
	input  wire sanp_mid_t          in_mid,
	output logic                    out_vld,
	output logic [29:0]             out_pixel,
	output logic [3:0]              out_face
);

	localparam int unsigned MW = MAX_ORDER;

	logic [ORDER_W-1:0] ord;
	logic [MW-1:0]      mask;

	assign ord  = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
	assign mask = ~({MW{1'b1}} << ord);

	logic vld_s1, vld_s2, vld_s3;
	logic eq_s1, neg_s1;
	logic [1:0]  ntt_s1;
	logic [37:0] tp_s1, tm_s1;
	logic [61:0] prp_s1;
	logic [62:0] prm_s1;
	logic [3:0]  face_s2, face_s3;
	logic [MW-1:0] ix_s2, iy_s2;
	logic [29:0] pixel_s3;

	logic [37:0] t1, t2;
	logic [30:0] fm;
	always_comb begin
		t1 = (38'd1 << 33) + {2'd0, in_mid.pc, 4'd0};
		t2 = {4'd0, in_mid.za, 1'b0} + {5'd0, in_mid.za};
		fm = 31'h4000_0000 - {1'b0, in_mid.pc[29:0]};
	end

	logic [5:0]  sh_e, sh_p;
	logic [37:0] jp_e, jm_e;
	logic [2:0]  ifp, ifm;
	logic [3:0]  face_e, face_p;
	logic [61:0] jp_w;
	logic [62:0] jm_w;
	logic [MW-1:0] jpc, jmc, ix_e, iy_e, ix_p, iy_p;
	always_comb begin
		sh_e = 6'd34 - {2'd0, ord};
		sh_p = 6'd62 - {2'd0, ord};
		jp_e = tp_s1 >> sh_e;
		jm_e = tm_s1 >> sh_e;
		ifp  = 3'(jp_e >> ord);
		ifm  = 3'(jm_e >> ord);
		if (ifp == ifm)
			face_e = {1'b0, ifp} | 4'd4;
		else if (ifp < ifm)
			face_e = {1'b0, ifp};
		else
			face_e = {1'b0, ifm} + 4'd8;
		ix_e = jm_e[MW-1:0] & mask;
		iy_e = ~jp_e[MW-1:0] & mask;
		jp_w = prp_s1 >> sh_p;
		jm_w = prm_s1 >> sh_p;
		jpc  = (jp_w > 62'(mask)) ? mask : jp_w[MW-1:0];
		jmc  = (jm_w > 63'(mask)) ? mask : jm_w[MW-1:0];
		if (neg_s1) begin
			ix_p   = jpc;
			iy_p   = jmc;
			face_p = {2'b10, ntt_s1};
		end else begin
			ix_p   = mask - jmc;
			iy_p   = mask - jpc;
			face_p = {2'b00, ntt_s1};
		end
	end

	logic [2*MW-1:0] il;
	always_comb begin
		for (int i = 0; i < MW; i++) begin
			il[2*i]   = ix_s2[i];
			il[2*i+1] = iy_s2[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eq_s1    <= (t2 <= (38'd1 << 33));
			neg_s1   <= in_mid.neg;
			ntt_s1   <= in_mid.pc[31:30];
			tp_s1    <= in_mid.neg ? (t1 + t2) : (t1 - t2);
			tm_s1    <= in_mid.neg ? (t1 - t2) : (t1 + t2);
			prp_s1   <= 62'(in_mid.pc[29:0]) * 62'(in_r);
			prm_s1   <= 63'(fm) * 63'(in_r);
			face_s2  <= eq_s1 ? face_e : face_p;
			ix_s2    <= eq_s1 ? ix_e : ix_p;
			iy_s2    <= eq_s1 ? iy_e : iy_p;
			face_s3  <= face_s2;
			pixel_s3 <= 30'({26'd0, face_s2} << {ord, 1'b0}) + 30'(il);
		end
	end

	assign out_vld   = vld_s3;
	assign out_pixel = pixel_s3;
	assign out_face  = face_s3;

endmodule
`default_nettype wire

FILE: rtl/sky_angle_to_nest_pixel.sv
// Maps a sky direction (colatitude and longitude codes) to its HEALPix nested
// pixel number and base face, with nside = 2^order set through the cfg port
// (order above 13 saturates). One transaction is accepted every clock cycle
// unless the pipeline is held by m_axis_tready. From input to output it folds
// the angle and squares it, runs the ten-term cosine series (per term: product,
// sum, reciprocal product, sum, correction), forms the polar radicand, takes the
// square root (two result bits per stage) and forms the face and bit interleave.
// The whole pipeline holds while a result waits on m_axis_tready.
`default_nettype none
module sky_angle_to_nest_pixel
	import sanp_pkg::*;
#(
	parameter int unsigned MAX_ORDER = MAX_ORDER_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // theta_code, phi_code
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata   // pixel_index, base_face, zero fill
);

	logic [3:0] order_q;
	logic       en;

	logic       cos_vld;
	logic [32:0] cos_za;
	sanp_side_t cos_side;

	logic        vld_s1;
	logic [63:0] v_s1;
	sanp_mid_t   mid_s1;

	logic        sq_vld;
	logic [31:0] sq_root;
	sanp_mid_t   sq_mid;

	logic        map_vld;
	logic [29:0] map_pixel;
	logic [3:0]  map_face;

	logic [32:0] diff;
	logic [34:0] w;

	assign en            = !map_vld || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			order_q <= ORDER_RESET;
		else if (cfg_we)
			order_q <= cfg_wdata;
	end

	sanp_cos u_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_axis_tvalid),
		.in_theta (s_axis_tdata[31:0]),
		.in_pc    (s_axis_tdata[63:32]),
		.out_vld  (cos_vld),
		.out_za   (cos_za),
		.out_side (cos_side)
	);

	always_comb begin
		diff = 33'h1_0000_0000 - cos_za;
		w    = {1'b0, diff, 1'b0} + {2'd0, diff};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= cos_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1       <= {w[31:0], 32'd0};
			mid_s1.za  <= cos_za;
			mid_s1.neg <= cos_side.neg;
			mid_s1.pc  <= cos_side.pc;
		end
	end

	sanp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.in_v     (v_s1),
		.in_mid   (mid_s1),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_mid  (sq_mid)
	);

	sanp_map #(
		.MAX_ORDER(MAX_ORDER)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.order     (order_q),
		.in_vld    (sq_vld),
		.in_r      (sq_root),
		.in_mid    (sq_mid),
		.out_vld   (map_vld),
		.out_pixel (map_pixel),
		.out_face  (map_face)
	);

	assign m_axis_tvalid = map_vld;
	assign m_axis_tdata  = {6'd0, map_face, map_pixel};

endmodule
`default_nettype wire
